// ----- rtl/core/ise_pkg.sv -----
`timescale 1ns / 1ps

package ise_pkg;

    localparam int SET_DEPTH = 16;
    localparam int IDX_W     = $clog2(SET_DEPTH);
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int RES_DEPTH = 2 * SET_DEPTH;
    localparam int RES_IDX_W = $clog2(RES_DEPTH);
    localparam int RES_W     = $clog2(RES_DEPTH + 1);
    localparam int Q_DEPTH   = 2;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int Q_IDX_W   = $clog2(Q_DEPTH);

    localparam int CMD_W    = 4;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_A  = 4'd0,
        CMD_REM_A  = 4'd1,
        CMD_QRY_A  = 4'd2,
        CMD_INS_B  = 4'd3,
        CMD_CLR_B  = 4'd4,
        CMD_UNION  = 4'd5,
        CMD_DIFF   = 4'd6,
        CMD_INTER  = 4'd7,
        CMD_EQUAL  = 4'd8,
        CMD_CLR_A  = 4'd9
    } t_cmd;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAME = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        t_cmd                     cmd;
        logic signed [VAL_W-1:0]  value;
        logic                     wb;
    } t_job;

    typedef struct packed {
        logic signed [VAL_W-1:0]  elem;
        logic                     elem_valid;
        logic [STATUS_W-1:0]      status;
        logic                     found;
        logic [COUNT_W-1:0]       count;
        logic                     last;
    } t_res;

endpackage

// ----- rtl/core/ise_if.sv -----
`timescale 1ns / 1ps

interface ise_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [ise_pkg::CMD_W-1:0]            cmd;
    logic signed [ise_pkg::VAL_W-1:0]     value;
    logic                                 write_back;

    modport source(output valid, cmd, value, write_back, input ready);
    modport sink(input valid, cmd, value, write_back, output ready);
endinterface

interface ise_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ise_pkg::VAL_W-1:0]     elem;
    logic                                 elem_valid;
    logic [ise_pkg::STATUS_W-1:0]         status;
    logic                                 found;
    logic [ise_pkg::COUNT_W-1:0]          count;
    logic                                 last;

    modport source(output valid, elem, elem_valid, status, found, count, last, input ready);
    modport sink(input valid, elem, elem_valid, status, found, count, last, output ready);
endinterface

// ----- rtl/core/ise_front.sv -----
`timescale 1ns / 1ps

module ise_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ise_in_if.sink        i_in,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output ise_pkg::t_job o_job
);
    import ise_pkg::*;

    t_job                 r_q [Q_DEPTH];
    logic [Q_IDX_W-1:0]   r_wp, r_rp;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic                 push, pop;
    t_job                 in_job;

    assign i_in.ready  = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign o_job_valid = (r_cnt != '0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    always_comb begin
        in_job.cmd   = t_cmd'(i_in.cmd);
        in_job.value = i_in.value;
        in_job.wb    = i_in.write_back;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + Q_CNT_W'(push) - Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_job;
        end
    end

`ifndef SYNTH
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("queue holds more than its depth");
`endif

endmodule

// ----- rtl/core/ise_back.sv -----
`timescale 1ns / 1ps

module ise_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  ise_pkg::t_job i_job,
    ise_out_if.source     o_out
);
    import ise_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN_A = 6'b000010,
        S_SCAN_B = 6'b000100,
        S_WB     = 6'b001000,
        S_EMIT   = 6'b010000,
        S_EQ     = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic signed [VAL_W-1:0] r_a [SET_DEPTH];
    logic signed [VAL_W-1:0] n_a [SET_DEPTH];
    logic signed [VAL_W-1:0] r_b [SET_DEPTH];
    logic signed [VAL_W-1:0] n_b [SET_DEPTH];
    logic signed [VAL_W-1:0] r_res [RES_DEPTH];
    logic signed [VAL_W-1:0] n_res [RES_DEPTH];
    logic [CNT_W-1:0]        r_acnt, n_acnt, r_bcnt, n_bcnt;
    logic [RES_W-1:0]        r_n, n_n, r_k, n_k;
    t_job                    r_job, n_job;
    logic                    r_eq, n_eq;
    logic [STATUS_W-1:0]     r_st, n_st;
    logic                    r_ovalid, n_ovalid;
    t_res                    r_out, n_out;

    logic                    out_free;
    logic signed [VAL_W-1:0] a_k, b_k, key_a, key_b;
    logic [SET_DEPTH-1:0]    hit_a, hit_b;
    logic                    in_a, in_b, seen, incl, emit_last;
    logic [RES_W-1:0]        k_ext_a, k_ext_b;

    assign out_free = !r_ovalid || o_out.ready;
    assign a_k      = r_a[r_k[IDX_W-1:0]];
    assign b_k      = r_b[r_k[IDX_W-1:0]];
    assign key_a    = (r_state == S_SCAN_B) ? b_k : i_job.value;
    assign key_b    = (r_state == S_IDLE) ? i_job.value : a_k;
    assign k_ext_a  = RES_W'(r_acnt);
    assign k_ext_b  = RES_W'(r_bcnt);

    // Both sets are compared in parallel against one key each cycle.
    always_comb begin
        for (int i = 0; i < SET_DEPTH; i++) begin
            hit_a[i] = (CNT_W'(i) < r_acnt) && (r_a[i] == key_a);
            hit_b[i] = (CNT_W'(i) < r_bcnt) && (r_b[i] == key_b);
        end
    end
    assign in_a = |hit_a;
    assign in_b = |hit_b;
    assign emit_last = (r_n == '0) || (RES_W'(r_k + 1'b1) == r_n);

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_res    = r_res;
        n_acnt   = r_acnt;
        n_bcnt   = r_bcnt;
        n_n      = r_n;
        n_k      = r_k;
        n_job    = r_job;
        n_eq     = r_eq;
        n_st     = r_st;
        n_ovalid = r_ovalid && !o_out.ready;
        n_out    = r_out;
        o_job_ready = 1'b0;
        seen     = 1'b0;
        incl     = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_job_ready = out_free;
                if (i_job_valid && out_free) begin
                    n_job       = i_job;
                    n_k         = '0;
                    n_n         = '0;
                    n_st        = ST_DONE;
                    n_out.elem       = i_job.value;
                    n_out.elem_valid = 1'b0;
                    n_out.status     = ST_DONE;
                    n_out.found      = 1'b0;
                    n_out.last       = 1'b1;
                    n_ovalid         = 1'b1;
                    case (i_job.cmd)
                        CMD_INS_A: begin
                            if (in_a) begin
                                n_out.status = ST_SAME;
                            end else if (r_acnt == CNT_W'(SET_DEPTH)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                n_a[r_acnt[IDX_W-1:0]] = i_job.value;
                                n_acnt = r_acnt + 1'b1;
                            end
                        end
                        CMD_REM_A: begin
                            if (in_a) begin
                                // Entries at and behind the hit move down one place.
                                for (int j = 0; j < SET_DEPTH - 1; j++) begin
                                    seen = seen | hit_a[j];
                                    if (seen) begin
                                        n_a[j] = r_a[j+1];
                                    end
                                end
                                n_acnt = r_acnt - 1'b1;
                            end else begin
                                n_out.status = ST_SAME;
                            end
                        end
                        CMD_QRY_A: n_out.found = in_a;
                        CMD_INS_B: begin
                            if (in_b) begin
                                n_out.status = ST_SAME;
                            end else if (r_bcnt == CNT_W'(SET_DEPTH)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                n_b[r_bcnt[IDX_W-1:0]] = i_job.value;
                                n_bcnt = r_bcnt + 1'b1;
                            end
                        end
                        CMD_CLR_B: n_bcnt = '0;
                        CMD_CLR_A: n_acnt = '0;
                        CMD_UNION, CMD_DIFF, CMD_INTER: begin
                            n_ovalid = r_ovalid && !o_out.ready;
                            n_state  = S_SCAN_A;
                        end
                        CMD_EQUAL: begin
                            n_ovalid = r_ovalid && !o_out.ready;
                            n_eq     = (r_acnt == r_bcnt);
                            n_state  = S_EQ;
                        end
                        default: n_out.status = ST_SAME;
                    endcase
                    n_out.count = COUNT_W'(n_acnt);
                end
            end
            S_SCAN_A: begin
                if (r_k < k_ext_a) begin
                    incl = (r_job.cmd == CMD_UNION)
                        || ((r_job.cmd == CMD_DIFF) && !in_b)
                        || ((r_job.cmd == CMD_INTER) && in_b);
                    if (incl) begin
                        n_res[r_n[RES_IDX_W-1:0]] = a_k;
                        n_n = r_n + 1'b1;
                    end
                    n_k = r_k + 1'b1;
                end else if (r_job.cmd == CMD_UNION) begin
                    n_k     = '0;
                    n_state = S_SCAN_B;
                end else begin
                    n_state = S_WB;
                end
            end
            S_SCAN_B: begin
                if (r_k < k_ext_b) begin
                    if (!in_a) begin
                        n_res[r_n[RES_IDX_W-1:0]] = b_k;
                        n_n = r_n + 1'b1;
                    end
                    n_k = r_k + 1'b1;
                end else begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (r_job.wb) begin
                    for (int i = 0; i < SET_DEPTH; i++) begin
                        if (RES_W'(i) < r_n) begin
                            n_a[i] = r_res[i];
                        end
                    end
                    if (r_n > RES_W'(SET_DEPTH)) begin
                        n_acnt = CNT_W'(SET_DEPTH);
                        n_st   = ST_FULL;
                    end else begin
                        n_acnt = r_n[CNT_W-1:0];
                    end
                end
                n_k     = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid         = 1'b1;
                    n_out.elem_valid = (r_n != '0);
                    n_out.elem       = (r_n != '0) ? r_res[r_k[RES_IDX_W-1:0]] : '0;
                    n_out.status     = r_st;
                    n_out.found      = 1'b0;
                    n_out.count      = COUNT_W'(r_acnt);
                    n_out.last       = emit_last;
                    n_k              = r_k + 1'b1;
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EQ: begin
                if (r_k < k_ext_a) begin
                    if (!in_b) begin
                        n_eq = 1'b0;
                    end
                    n_k = r_k + 1'b1;
                end else if (out_free) begin
                    n_ovalid         = 1'b1;
                    n_out.elem       = r_job.value;
                    n_out.elem_valid = 1'b0;
                    n_out.status     = ST_DONE;
                    n_out.found      = r_eq;
                    n_out.count      = COUNT_W'(r_acnt);
                    n_out.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acnt   <= '0;
            r_bcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acnt   <= n_acnt;
            r_bcnt   <= n_bcnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_res <= n_res;
        r_n   <= n_n;
        r_k   <= n_k;
        r_job <= n_job;
        r_eq  <= n_eq;
        r_st  <= n_st;
        r_out <= n_out;
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.elem       = r_out.elem;
    assign o_out.elem_valid = r_out.elem_valid;
    assign o_out.status     = r_out.status;
    assign o_out.found      = r_out.found;
    assign o_out.count      = r_out.count;
    assign o_out.last       = r_out.last;

`ifndef SYNTH
    a_acnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acnt <= CNT_W'(SET_DEPTH)) && (r_bcnt <= CNT_W'(SET_DEPTH)))
        else $error("set count above capacity");
    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_n <= RES_W'(RES_DEPTH)) && (r_k <= r_n))
        else $error("result stream index out of range");
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && out_free && emit_last) |=> (r_state == S_IDLE) && r_out.last)
        else $error("stream end not followed by idle");
`endif

endmodule

// ----- rtl/core/integer_set_engine_core.sv -----
`timescale 1ns / 1ps

// Integer set engine: keeps two sets A and B of up to SET_DEPTH signed 32-bit values.
// The input channel carries one command per beat (cmd, value, write_back). The
// output channel carries result beats; the final beat of a command has last set.
// A two-beat command queue sits behind the input, so new beats are taken while
// the engine works or while a result waits on a stalled receiver.
// Single-value commands (insert, remove, query, clear) give their one result beat
// through the queue entry and the output register, one command per cycle sustained
// while the receiver takes each beat. Equality scans A one entry per cycle.
// Union, difference and intersection scan A (and B for union) one entry per
// cycle against a parallel compare of the other set, pass through a write-back
// state, then send one beat per cycle while the receiver takes each beat.
// The single scan counter and the one-beat output register set this pacing.
// Reset empties both sets and the queue; stored values are not cleared.
// A stalled receiver holds the output beat; the engine waits and the queue fills.
module integer_set_engine_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ise_in_if.sink    i_in,
    ise_out_if.source o_out
);
    import ise_pkg::*;

    logic job_valid, job_ready;
    t_job job;

    ise_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    ise_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_out       (o_out)
    );

endmodule
